// File: rtl/byte_ring_fifo_assert.svh
// Assertion macros for the byte ring FIFO checker.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

// Same-cycle implication.
`define BRF_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte_ring_fifo check failed");

// Next-cycle implication.
`define BRF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte_ring_fifo check failed");

`endif

// File: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Types and fixed widths shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int ACTION_W = 3;
	localparam int BYTE_W   = 8;
	localparam int AMT_W    = 13;
	localparam int CNT_W    = 12;
	localparam int BURST_W  = 7;

	typedef enum logic [ACTION_W-1:0] {
		OP_ENQ  = 3'd0,
		OP_DEQ  = 3'd1,
		OP_PEEK = 3'd2,
		OP_MVT  = 3'd3,
		OP_MVH  = 3'd4,
		OP_NOP  = 3'd5
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic              neg;
		logic [AMT_W-1:0]  mag;
	} cmd_t;

endpackage

// File: rtl/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Each accepted item passes through the two-entry command queue. The back pops
// it while idle and registers its result through the report state, or each byte
// of a dequeue or peek through the read and wait states, as the byte store has a
// registered read port. The back pops no new item until its last result is loaded.
// Reset: pointers cleared, slot count DEPTH, byte store contents undefined.
// ----------------------------------------------------------------------------
module byte_ring_fifo import brf_pkg::*; #(
	parameter int DEPTH     = 4096,
	parameter int MAX_BURST = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [AMT_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACTION_W-1:0]     action,
	input  logic [BYTE_W-1:0]       data_byte,
	input  logic signed [AMT_W-1:0] amount,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [BYTE_W-1:0]       data_out,
	output logic                    data_valid,
	output logic signed [AMT_W-1:0] done_count,
	output logic [CNT_W-1:0]        used_bytes,
	output logic [CNT_W-1:0]        free_bytes,
	output logic                    last
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	logic [AMT_W-1:0] done_raw;

	brf_front #(
		.MAX_BURST(MAX_BURST)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.amount    (amount),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	brf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_cmd   (q_cmd)
	);

	brf_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.data_valid(data_valid),
		.done_count(done_raw),
		.used_bytes(used_bytes),
		.free_bytes(free_bytes),
		.last      (last)
	);

	assign done_count = signed'(done_raw);

endmodule

// File: rtl/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front
// Accepts items, decodes the action and prepares the count or shift magnitude.
// ----------------------------------------------------------------------------
module brf_front import brf_pkg::*; #(
	parameter int MAX_BURST = 64
) (
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACTION_W-1:0]     action,
	input  logic [BYTE_W-1:0]       data_byte,
	input  logic signed [AMT_W-1:0] amount,
	output logic                    push_valid,
	input  logic                    push_ready,
	output cmd_t                    push_cmd
);

	logic             neg;
	logic [AMT_W-1:0] abs_amt;

	assign neg     = amount[AMT_W-1];
	assign abs_amt = neg ? AMT_W'(-amount) : AMT_W'(amount);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_cmd.data = data_byte;
		push_cmd.neg  = 1'b0;
		push_cmd.mag  = '0;
		case (action)
			OP_ENQ: begin
				push_cmd.op = OP_ENQ;
			end
			OP_DEQ, OP_PEEK: begin
				push_cmd.op = op_t'(action);
				// non-positive counts read nothing; cap at the burst limit
				if (!neg) begin
					push_cmd.mag = (abs_amt > AMT_W'(MAX_BURST)) ? AMT_W'(MAX_BURST)
						: abs_amt;
				end
			end
			OP_MVT, OP_MVH: begin
				push_cmd.op  = op_t'(action);
				push_cmd.neg = neg;
				push_cmd.mag = abs_amt;
			end
			default: begin
				push_cmd.op = OP_NOP;
			end
		endcase
	end

endmodule

// File: rtl/brf_queue.sv
// ----------------------------------------------------------------------------
// brf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module brf_queue import brf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int QD = 2;

	cmd_t                   entry_q [QD];
	logic [$clog2(QD)-1:0]  wr_q;
	logic [$clog2(QD)-1:0]  rd_q;
	logic [$clog2(QD+1)-1:0] cnt_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (cnt_q != ($clog2(QD+1))'(QD));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back
// Owns the pointers and the byte store; executes commands and drives results.
// ----------------------------------------------------------------------------
module brf_back import brf_pkg::*; #(
	parameter int DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [AMT_W-1:0]   cfg_wdata,
	input  logic               q_valid,
	output logic               q_ready,
	input  cmd_t               q_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  data_out,
	output logic               data_valid,
	output logic [AMT_W-1:0]   done_count,
	output logic [CNT_W-1:0]   used_bytes,
	output logic [CNT_W-1:0]   free_bytes,
	output logic               last
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = PW + 1;
	localparam int SW = (CW > AMT_W) ? CW : AMT_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REPORT = 4'b0010,
		ST_READ   = 4'b0100,
		ST_WAIT   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       head_q;
	logic [PW-1:0]       tail_q;
	logic [CW-1:0]       slot_q;
	logic [PW-1:0]       rd_q;
	logic [BURST_W-1:0]  cnt_q;
	logic [AMT_W-1:0]    done_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   data_q;
	logic                data_valid_q;
	logic [AMT_W-1:0]    done_count_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    free_q;
	logic                last_q;
	logic [BYTE_W-1:0]   mem_q [DEPTH];
	logic [BYTE_W-1:0]   rdata_q;

	logic [CW-1:0] diff;
	logic [CW-1:0] used_w;
	logic [PW-1:0] used_c;
	logic [PW-1:0] free_c;
	logic [CW-1:0] tail_inc_w;
	logic [PW-1:0] tail_inc;
	logic [CW-1:0] head_inc_w;
	logic [PW-1:0] head_inc;
	logic [CW-1:0] rd_inc_w;
	logic [PW-1:0] rd_inc;
	logic [SW-1:0] mag_e;
	logic [SW-1:0] n_w;
	logic [PW-1:0] n_c;
	logic [CW-1:0] head_adv_w;
	logic [PW-1:0] head_adv;
	logic [PW-1:0] lim;
	logic [PW-1:0] mv_mag;
	logic [PW-1:0] mv_ptr;
	logic [CW-1:0] mv_up_w;
	logic [CW-1:0] mv_dn_w;
	logic [PW-1:0] mv_new;
	logic [SW-1:0] mv_done;
	logic [SW-1:0] cfg_e;
	logic [CW-1:0] cfg_sat;
	logic          pop;
	logic          out_free;
	logic          out_load;
	logic          mem_we;

	// occupancy
	assign diff   = {1'b0, tail_q} - {1'b0, head_q};
	assign used_w = (tail_q >= head_q) ? diff : diff + slot_q;
	assign used_c = used_w[PW-1:0];
	assign free_c = PW'(slot_q - CW'(1) - used_w);

	// pointer increments with wrap at the slot count
	assign tail_inc_w = {1'b0, tail_q} + CW'(1);
	assign tail_inc   = (tail_inc_w >= slot_q) ? '0 : tail_inc_w[PW-1:0];
	assign head_inc_w = {1'b0, head_q} + CW'(1);
	assign head_inc   = (head_inc_w >= slot_q) ? '0 : head_inc_w[PW-1:0];
	assign rd_inc_w   = {1'b0, rd_q} + CW'(1);
	assign rd_inc     = (rd_inc_w >= slot_q) ? '0 : rd_inc_w[PW-1:0];

	// burst length
	assign mag_e      = SW'(q_cmd.mag);
	assign n_w        = (mag_e > SW'(used_c)) ? SW'(used_c) : mag_e;
	assign n_c        = PW'(n_w);
	assign head_adv_w = {1'b0, head_q} + {1'b0, n_c};
	assign head_adv   = (head_adv_w >= slot_q) ? PW'(head_adv_w - slot_q)
		: head_adv_w[PW-1:0];

	// pointer moves
	always_comb begin
		if (q_cmd.op == OP_MVT) begin
			lim    = q_cmd.neg ? used_c : free_c;
			mv_ptr = tail_q;
		end else begin
			lim    = q_cmd.neg ? free_c : used_c;
			mv_ptr = head_q;
		end
	end

	assign mv_mag  = (mag_e > SW'(lim)) ? lim : PW'(q_cmd.mag);
	assign mv_up_w = {1'b0, mv_ptr} + {1'b0, mv_mag};
	assign mv_dn_w = {1'b0, mv_ptr} + slot_q - {1'b0, mv_mag};

	always_comb begin
		if (!q_cmd.neg) begin
			mv_new = (mv_up_w >= slot_q) ? PW'(mv_up_w - slot_q) : mv_up_w[PW-1:0];
		end else if (mv_ptr >= mv_mag) begin
			mv_new = mv_ptr - mv_mag;
		end else begin
			mv_new = mv_dn_w[PW-1:0];
		end
	end

	assign mv_done = q_cmd.neg ? SW'(-SW'(mv_mag)) : SW'(mv_mag);

	// slot count saturation
	assign cfg_e   = SW'(cfg_wdata);
	assign cfg_sat = (cfg_e < SW'(2)) ? CW'(2)
		: (cfg_e > SW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_e);

	assign q_ready  = (state_q == ST_IDLE);
	assign pop      = q_valid && q_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && !cfg_we && ((state_q == ST_REPORT) || (state_q == ST_WAIT));
	assign mem_we   = pop && (q_cmd.op == OP_ENQ) && (free_c != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			slot_q      <= CW'(DEPTH);
			rd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				slot_q <= cfg_sat;
				head_q <= '0;
				tail_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (pop) begin
							case (q_cmd.op)
								OP_ENQ: begin
									state_q <= ST_REPORT;
									if (free_c != '0) begin
										tail_q <= tail_inc;
									end
								end
								OP_DEQ, OP_PEEK: begin
									if (n_w != '0) begin
										state_q <= ST_READ;
										rd_q    <= head_inc;
										cnt_q   <= BURST_W'(n_w);
										if (q_cmd.op == OP_DEQ) begin
											head_q <= head_adv;
										end
									end else begin
										state_q <= ST_REPORT;
									end
								end
								OP_MVT: begin
									state_q <= ST_REPORT;
									tail_q  <= mv_new;
								end
								OP_MVH: begin
									state_q <= ST_REPORT;
									head_q  <= mv_new;
								end
								default: begin
									state_q <= ST_REPORT;
								end
							endcase
						end
					end
					ST_REPORT: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					ST_READ: begin
						rd_q    <= rd_inc;
						state_q <= ST_WAIT;
					end
					ST_WAIT: begin
						if (out_free) begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= (cnt_q == BURST_W'(1)) ? ST_IDLE : ST_READ;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			case (q_cmd.op)
				OP_ENQ:          done_q <= AMT_W'(free_c != '0);
				OP_DEQ, OP_PEEK: done_q <= AMT_W'(n_w);
				OP_MVT, OP_MVH:  done_q <= AMT_W'(mv_done);
				default:         done_q <= '0;
			endcase
		end
		if (out_load) begin
			done_count_q <= done_q;
			used_q       <= CNT_W'(used_c);
			free_q       <= CNT_W'(free_c);
			if (state_q == ST_WAIT) begin
				data_q       <= rdata_q;
				data_valid_q <= 1'b1;
				last_q       <= (cnt_q == BURST_W'(1));
			end else begin
				data_q       <= '0;
				data_valid_q <= 1'b0;
				last_q       <= 1'b1;
			end
		end
	end

	// byte store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[tail_inc] <= q_cmd.data;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem_q[rd_q];
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_q;
	assign data_valid = data_valid_q;
	assign done_count = done_count_q;
	assign used_bytes = used_q;
	assign free_bytes = free_q;
	assign last       = last_q;

endmodule

// File: rtl/brf_checker.sv
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks on the byte ring FIFO results, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_assert.svh"

module brf_checker import brf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [BYTE_W-1:0]       data_out,
	input logic                    data_valid,
	input logic signed [AMT_W-1:0] done_count,
	input logic                    last
);

	// stalled item holds
	`BRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({data_out, last}))

	// an item without a byte is a single, zeroed result
	`BRF_ASSERT_NOW(a_nobyte_single, out_valid && !data_valid, last && (data_out == '0))

	// bytes come only from a positive read count
	`BRF_ASSERT_NOW(a_byte_count, out_valid && data_valid, !done_count[AMT_W-1] && (done_count != '0))

	// only burst results may be non-final
	`BRF_ASSERT_NOW(a_nonlast_byte, out_valid && !last, data_valid)

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);

// File: verif/tb_byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo
// Self-checking bench for the circular byte FIFO. A tracker class mirrors the
// pointers, slot count and byte store, and it queues the results that each
// accepted item should produce. The bench starts with directed items: empty
// and full cases, clamped bursts, pointer moves at both extremes and reserved
// actions. It then runs random phases over a range of slot counts. Both
// handshakes stall at random, except during one stretch with no stalls.
// ----------------------------------------------------------------------------
import brf_pkg::*;

typedef struct packed {
	logic [BYTE_W-1:0] data;
	logic              dv;
	logic [AMT_W-1:0]  done;
	logic [CNT_W-1:0]  used;
	logic [CNT_W-1:0]  room;
	logic              last;
} ring_result_t;

class ring_tracker;
	localparam int DEPTH     = 4096;
	localparam int MAX_BURST = 64;

	logic [BYTE_W-1:0] store [DEPTH];
	bit                written [DEPTH];
	int                head = 0;
	int                tail = 0;
	int                slots = DEPTH;
	ring_result_t      pending_results [$];
	int                mismatches = 0;

	function int used_cnt();
		return (tail + slots - head) % slots;
	endfunction

	function int room_cnt();
		return slots - 1 - used_cnt();
	endfunction

	function void set_slots(int v);
		slots = (v < 2) ? 2 : ((v > DEPTH) ? DEPTH : v);
		head  = 0;
		tail  = 0;
	endfunction

	function int burst_size(int a);
		int n;
		n = (a > 0) ? a : 0;
		if (n > used_cnt())
			n = used_cnt();
		if (n > MAX_BURST)
			n = MAX_BURST;
		return n;
	endfunction

	// bytes after head that hold written data, up to n
	function int readable(int n);
		int k;
		k = 0;
		while (k < n && written[(head + 1 + k) % slots])
			k++;
		return k;
	endfunction

	function void push(logic [BYTE_W-1:0] d, logic dv, int done, logic lst);
		ring_result_t r;
		r.data = d;
		r.dv   = dv;
		r.done = done[AMT_W-1:0];
		r.used = CNT_W'(used_cnt());
		r.room = CNT_W'(room_cnt());
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	function void apply_item(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
			logic signed [AMT_W-1:0] amt);
		int                u;
		int                r;
		int                n;
		int                a;
		int                lim_pos;
		int                lim_neg;
		logic [BYTE_W-1:0] burst [MAX_BURST];
		u = used_cnt();
		r = room_cnt();
		a = int'(amt);
		case (act)
			OP_ENQ: begin
				n = 0;
				if (r > 0) begin
					tail          = (tail + 1) % slots;
					store[tail]   = b;
					written[tail] = 1'b1;
					n             = 1;
				end
				push('0, 1'b0, n, 1'b1);
			end
			OP_DEQ, OP_PEEK: begin
				n = burst_size(a);
				if (n == 0) begin
					push('0, 1'b0, 0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						burst[i] = store[(head + 1 + i) % slots];
					if (act == OP_DEQ)
						head = (head + n) % slots;
					for (int i = 0; i < n; i++)
						push(burst[i], 1'b1, n, i == n - 1);
				end
			end
			OP_MVT, OP_MVH: begin
				lim_pos = (act == OP_MVT) ? r : u;
				lim_neg = (act == OP_MVT) ? u : r;
				if (a > lim_pos)
					a = lim_pos;
				if (a < -lim_neg)
					a = -lim_neg;
				if (act == OP_MVT)
					tail = (tail + slots + a) % slots;
				else
					head = (head + slots + a) % slots;
				push('0, 1'b0, a, 1'b1);
			end
			default: begin
				push('0, 1'b0, 0, 1'b1);
			end
		endcase
	endfunction

	task report(string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task check_result(ring_result_t got);
		ring_result_t want;
		if (pending_results.size() == 0) begin
			report($sformatf("result with nothing pending: data=%h dv=%b done=%0d",
				got.data, got.dv, $signed(got.done)));
			return;
		end
		want = pending_results.pop_front();
		if (got.data !== want.data || got.dv !== want.dv || got.done !== want.done ||
				got.used !== want.used || got.room !== want.room ||
				got.last !== want.last)
			report($sformatf({"got data=%h dv=%b done=%0d used=%0d free=%0d last=%b, ",
				"want data=%h dv=%b done=%0d used=%0d free=%0d last=%b"},
				got.data, got.dv, $signed(got.done), got.used, got.room, got.last,
				want.data, want.dv, $signed(want.done), want.used, want.room,
				want.last));
	endtask
endclass

module tb_byte_ring_fifo;
	localparam int STALL_LIMIT = 2000;
	localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [AMT_W-1:0]        cfg_wdata = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [ACTION_W-1:0]     action    = '0;
	logic [BYTE_W-1:0]       data_byte = '0;
	logic signed [AMT_W-1:0] amount    = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [BYTE_W-1:0]       data_out;
	logic                    data_valid;
	logic signed [AMT_W-1:0] done_count;
	logic [CNT_W-1:0]        used_bytes;
	logic [CNT_W-1:0]        free_bytes;
	logic                    last;

	bit          steady = 1'b0;
	int          stall_cycles = 0;
	ring_tracker ring;

	byte_ring_fifo uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.data_byte  (data_byte),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.data_valid (data_valid),
		.done_count (done_count),
		.used_bytes (used_bytes),
		.free_bytes (free_bytes),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ring.check_result({data_out, data_valid, done_count, used_bytes,
					free_bytes, last});
			out_ready <= steady || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
			input int a);
		while (!steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= b;
		amount    <= AMT_W'(a);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ring.apply_item(act, b, AMT_W'(a));
	endtask

	// slot count may only change once the FIFO has drained
	task automatic write_slots(input int v);
		in_valid <= 1'b0;
		while (ring.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= AMT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		ring.set_slots(v);
	endtask

	task automatic run_phase(input int cfg, input int fill, input int count);
		int                  r;
		int                  a;
		int                  n;
		logic [ACTION_W-1:0] act;
		write_slots(cfg);
		repeat (fill) send_item(OP_ENQ, BYTE_W'($urandom_range(255)), 0);
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 38)
				act = OP_ENQ;
			else if (r < 58)
				act = OP_DEQ;
			else if (r < 70)
				act = OP_PEEK;
			else if (r < 81)
				act = OP_MVT;
			else if (r < 92)
				act = OP_MVH;
			else
				act = ACTION_W'($urandom_range(7, 5));
			r = $urandom_range(99);
			if (r < 55)
				a = int'($urandom_range(ring.slots + 1));
			else if (r < 70)
				a = 0 - int'($urandom_range(ring.slots + 1));
			else if (r < 82)
				a = int'($urandom_range(8190)) - 4095;
			else if (r < 89)
				a = 4095;
			else if (r < 95)
				a = -4095;
			else
				a = 0;
			if (a > 4095)
				a = 4095;
			if (a < -4095)
				a = -4095;
			// keep bursts off slots that were never written
			if (act == OP_DEQ || act == OP_PEEK) begin
				n = ring.burst_size(a);
				if (ring.readable(n) < n)
					a = ring.readable(n);
			end
			send_item(act, BYTE_W'($urandom_range(255)), a);
		end
	endtask

	initial begin
		ring = new;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset slot count: empty reads, clamped bursts, pointer extremes
		send_item(OP_DEQ, 8'h00, 5);
		send_item(OP_PEEK, 8'h00, 0);
		send_item(OP_ENQ, 8'h00, 0);
		send_item(OP_ENQ, 8'hff, -4095);
		send_item(OP_ENQ, 8'ha5, 4095);
		send_item(OP_PEEK, 8'h00, 4095);
		send_item(OP_DEQ, 8'h00, -4095);
		send_item(OP_DEQ, 8'h00, 2);
		send_item(OP_MVT, 8'h00, 4095);
		send_item(OP_MVT, 8'h00, -4095);
		send_item(OP_MVH, 8'h00, 4095);
		send_item(OP_MVH, 8'h00, -4095);
		send_item(OP_MVH, 8'h00, 4095);
		send_item(OP_NOP, 8'h5a, 7);
		send_item(ACT_RSVD6, 8'h00, -1);
		send_item(ACT_RSVD7, 8'hff, 4095);

		// slot count below range: one usable byte
		write_slots(0);
		send_item(OP_ENQ, 8'h12, 0);
		send_item(OP_ENQ, 8'h34, 0);
		send_item(OP_MVT, 8'h00, 1);
		send_item(OP_MVH, 8'h00, -1);
		send_item(OP_PEEK, 8'h00, 64);
		send_item(OP_DEQ, 8'h00, 4095);
		send_item(OP_MVT, 8'h00, -1);
		send_item(OP_MVH, 8'h00, 1);

		run_phase(3, 0, 35);
		run_phase(8191, 70, 30);
		run_phase(5, 0, 35);
		steady = 1'b1;
		run_phase(17, 17, 35);
		steady = 1'b0;
		run_phase(64, 0, 35);
		run_phase(200, 70, 35);
		run_phase($urandom_range(300, 2), 0, 35);
		run_phase(4096, 0, 30);
		run_phase(1, 0, 25);
		run_phase(9, 10, 35);

		in_valid <= 1'b0;
		while (ring.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (ring.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/brf_pkg.sv
rtl/brf_front.sv
rtl/brf_queue.sv
rtl/brf_back.sv
rtl/byte_ring_fifo.sv
rtl/brf_checker.sv
verif/tb_byte_ring_fifo.sv
